// ===== design/hsd_pkg.sv =====
// shared types and constants of the huffman stream decoder
package hsd_pkg;

    // field widths of the stream items
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 32;
    localparam int BYTE_BITS  = 8;
    localparam int NBITS_W    = 4;
    localparam int ENTRY_W    = LEN_W + CODE_W;

    // input tdata layout, lowest field first
    localparam int S_TDATA_W  = 64;
    localparam int SYM_LSB    = 0;
    localparam int LEN_LSB    = SYM_LSB + SYM_W;
    localparam int CODE_LSB   = LEN_LSB + LEN_W;
    localparam int BYTE_LSB   = CODE_LSB + CODE_W;
    localparam int NBITS_LSB  = BYTE_LSB + BYTE_BITS;

    localparam int M_TDATA_W  = SYM_W;

    // item kinds carried on s_tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // result kinds carried on m_tuser
    localparam logic STATUS_SYMBOL   = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;      // input transfer taken this cycle
        logic shift_bit;   // move next data bit into the prefix
        logic scan_start;  // restart the table sweep
        logic scan_run;    // advance the table sweep
        logic take_hit;    // latch matched symbol
        logic take_ovf;    // latch overflow result
        logic load_pend;   // move latched result into pending slot
        logic push_pend;   // move pending result to output register
        logic push_last;   // pushed result closes the item
        logic clear_prefix;
    } hsd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_decode;
        logic hit;
        logic scan_done;
        logic prefix_full;
        logic more_bits;
        logic final_byte;
        logic pend_valid;
        logic out_free;
    } hsd_stat_t;

endpackage

// ===== design/hsd_ram.sv =====
// generic single-write, single-read ram with registered read data
module hsd_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/hsd_ctrl.sv =====
// controller state machine of the huffman stream decoder
module hsd_ctrl
    import hsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  hsd_stat_t stat,
    output hsd_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_NEXT   = 6'b000010,
        ST_SHIFT  = 6'b000100,
        ST_SEARCH = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_FLUSH  = 6'b100000
    } hsd_state_t;

    hsd_state_t state_reg, state_next;
    logic       can_push;

    assign s_tready = (state_reg == ST_IDLE);
    // a pending result may only leave when the output register has room
    assign can_push = !stat.pend_valid || stat.out_free;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.in_decode) begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                if (stat.more_bits) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_SHIFT: begin
                cmd.shift_bit  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.scan_run = 1'b1;
                priority if (stat.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_RESULT;
                end else if (stat.scan_done && stat.prefix_full) begin
                    cmd.take_ovf = 1'b1;
                    state_next   = ST_RESULT;
                end else if (stat.scan_done) begin
                    state_next = ST_NEXT;
                end
            end
            ST_RESULT: begin
                if (can_push) begin
                    cmd.push_pend    = stat.pend_valid;
                    cmd.load_pend    = 1'b1;
                    cmd.clear_prefix = 1'b1;
                    state_next       = ST_NEXT;
                end
            end
            ST_FLUSH: begin
                if (can_push) begin
                    cmd.push_pend    = stat.pend_valid;
                    cmd.push_last    = 1'b1;
                    cmd.clear_prefix = stat.final_byte;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // a result is only pushed when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_pend |-> stat.out_free)
        else $error("result pushed into a full output register");

    // a pending result is never overwritten without being pushed first
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_pend && stat.pend_valid) |-> cmd.push_pend)
        else $error("pending result lost");

    // decoding leaves the idle state only after an accepted decode transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && state_next == ST_NEXT) |-> (cmd.accept && stat.in_decode))
        else $error("decode started without an input transfer");
`endif

endmodule

// ===== design/hsd_datapath.sv =====
// datapath of the huffman stream decoder: table, prefix, sweep and result registers
module hsd_datapath
    import hsd_pkg::*;
#(
    parameter int MAX_CODE_LEN  = 32,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    input  hsd_cmd_t              cmd,
    output hsd_stat_t             stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = MAX_CODE_LEN;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    // input fields
    logic [SYM_W-1:0]     in_sym;
    logic [LEN_W-1:0]     in_len;
    logic [CODE_W-1:0]    in_code;
    logic [BYTE_BITS-1:0] in_byte;
    logic [NBITS_W-1:0]   in_nbits;
    logic [NBITS_W-1:0]   in_nbits_sat;
    logic                 tbl_we;

    assign in_sym   = s_tdata[SYM_LSB   +: SYM_W];
    assign in_len   = s_tdata[LEN_LSB   +: LEN_W];
    assign in_code  = s_tdata[CODE_LSB  +: CODE_W];
    assign in_byte  = s_tdata[BYTE_LSB  +: BYTE_BITS];
    assign in_nbits = s_tdata[NBITS_LSB +: NBITS_W];
    assign in_nbits_sat = (in_nbits > NBITS_W'(BYTE_BITS)) ? NBITS_W'(BYTE_BITS) : in_nbits;

    // symbols beyond the table are dropped
    assign tbl_we = cmd.accept && (s_tuser == CMD_LOAD) &&
                    ({1'b0, in_sym} < (SYM_W + 1)'(TABLE_ENTRIES));

    // entry valid flags, cleared at reset
    logic [TABLE_ENTRIES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (tbl_we) begin
            valid_reg[in_sym[AW-1:0]] <= (in_len != '0);
        end
    end

    // table sweep counters
    logic [AW:0]        scan_reg;
    logic               chk_vld_reg;
    logic [AW-1:0]      chk_addr_reg;
    logic               issue;
    logic [ENTRY_W-1:0] rd_data;

    assign issue = cmd.scan_run && (scan_reg < (AW + 1)'(TABLE_ENTRIES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            chk_vld_reg <= issue;
            if (issue) begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            chk_addr_reg <= scan_reg[AW-1:0];
        end
    end

    // code table: length above code bits
    hsd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (in_sym[AW-1:0]),
        .wdata ({in_len, in_code}),
        .re    (issue),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // running prefix, its length and a mask of its valid bits
    logic [PW-1:0]        prefix_reg;
    logic [PW-1:0]        mask_reg;
    logic [LW-1:0]        plen_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [NBITS_W-1:0]   nbits_reg;
    logic [NBITS_W-1:0]   bitcnt_reg;
    logic                 final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            mask_reg   <= '0;
            plen_reg   <= '0;
        end else if (cmd.clear_prefix) begin
            prefix_reg <= '0;
            mask_reg   <= '0;
            plen_reg   <= '0;
        end else if (cmd.shift_bit) begin
            prefix_reg <= (prefix_reg << 1) | PW'(byte_reg[BYTE_BITS-1]);
            mask_reg   <= (mask_reg << 1) | PW'(1'b1);
            plen_reg   <= plen_reg + 1'b1;
        end
    end

    // current data byte, consumed msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbits_reg  <= '0;
            bitcnt_reg <= '0;
            final_reg  <= 1'b0;
        end else if (cmd.accept && (s_tuser == CMD_DECODE)) begin
            nbits_reg  <= in_nbits_sat;
            bitcnt_reg <= '0;
            final_reg  <= s_tlast;
        end else if (cmd.shift_bit) begin
            bitcnt_reg <= bitcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_tuser == CMD_DECODE)) begin
            byte_reg <= in_byte;
        end else if (cmd.shift_bit) begin
            byte_reg <= byte_reg << 1;
        end
    end

    // compare the swept entry with the prefix
    logic [PW+CODE_W-1:0] code_wide;
    logic [PW-1:0]        code_ext;
    logic                 len_eq;
    logic                 code_eq;
    logic                 hit;

    assign code_wide = {{PW{1'b0}}, rd_data[CODE_W-1:0]};
    assign code_ext  = code_wide[PW-1:0];
    assign len_eq    = (7'(rd_data[ENTRY_W-1:CODE_W]) == 7'(plen_reg));
    assign code_eq   = ((code_ext & mask_reg) == prefix_reg);
    assign hit       = chk_vld_reg && valid_reg[chk_addr_reg] && len_eq && code_eq;

    // latched result, pending result and output register
    logic [SYM_W-1:0] found_sym_reg;
    logic             found_ovf_reg;
    logic             pend_vld_reg;
    logic [SYM_W-1:0] pend_sym_reg;
    logic             pend_ovf_reg;
    logic             out_vld_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_hit) begin
            found_sym_reg <= SYM_W'(chk_addr_reg);
            found_ovf_reg <= STATUS_SYMBOL;
        end else if (cmd.take_ovf) begin
            found_sym_reg <= '0;
            found_ovf_reg <= STATUS_OVERFLOW;
        end
    end

    // the pending slot holds one result back until it is known whether it is last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
        end else if (cmd.load_pend) begin
            pend_vld_reg <= 1'b1;
        end else if (cmd.push_pend) begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pend) begin
            pend_sym_reg <= found_sym_reg;
            pend_ovf_reg <= found_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.push_pend) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_pend) begin
            out_sym_reg  <= pend_sym_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

    // status to the controller
    always_comb begin
        stat.in_decode   = (s_tuser == CMD_DECODE);
        stat.hit         = hit;
        stat.scan_done   = chk_vld_reg && !hit &&
                           (chk_addr_reg == AW'(TABLE_ENTRIES - 1));
        stat.prefix_full = (plen_reg == LW'(MAX_CODE_LEN));
        stat.more_bits   = (bitcnt_reg < nbits_reg);
        stat.final_byte  = final_reg;
        stat.pend_valid  = pend_vld_reg;
        stat.out_free    = !out_vld_reg || m_tready;
    end

`ifndef SYNTHESIS
    // the prefix never grows past the longest code
    assert property (@(posedge aclk) disable iff (!aresetn)
        plen_reg <= LW'(MAX_CODE_LEN))
        else $error("prefix longer than the maximum code length");

    // the mask tracks the prefix length
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(mask_reg) == 32'(plen_reg))
        else $error("prefix mask out of step with prefix length");

    // prefix bits outside the mask stay clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (prefix_reg & ~mask_reg) == '0)
        else $error("stray prefix bits above the prefix length");
`endif

endmodule

// ===== design/huffman_stream_decoder.sv =====
// huffman stream decoder: a load item writes one code table entry
// a decode item is worked through bit by bit, one item at a time
// each data bit is checked by sweeping the code table ram, one entry per cycle
// the sweep stops at the first match, so low symbols are found sooner
// results wait in one pending slot and one output register; stalls add cycles
// aresetn (synchronous, active low) clears the entry valid flags, prefix and results
module huffman_stream_decoder
    import hsd_pkg::*;
#(
    parameter int MAX_CODE_LEN  = 32,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // symbol[7:0], code_length[13:8], code_bits[45:14], data_byte[53:46],
    // valid_bits[57:54], zero[63:58]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // final_byte
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // decoded_symbol[7:0]
    output logic                 m_tuser,   // status
    output logic                 m_tlast    // last
);

    hsd_cmd_t  cmd;
    hsd_stat_t stat;

    // sequencing of bits, sweeps and result transfers
    hsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, prefix and result storage
    hsd_datapath #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
